FILE: src/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg: shared constants for the incremental PID drive
// Register map, reset values and datapath widths used by the top level
// and by the iterative divider.
// ----------------------------------------------------------------------------
`default_nettype none

package ipd_pkg;

  // default sample width in bits (range 8..16)
  localparam int SAMPLE_BITS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_WINDOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_DIVISOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX      = 3'd6;

  // field widths
  localparam int GAIN_W  = 16;
  localparam int DRIVE_W = 8;
  localparam int SUM_W   = 32;   // control sum and dividend magnitude
  localparam int DIV_W   = 16;   // divisor
  localparam int ACC_W   = 42;   // wide accumulator, holds sum plus three terms

  // register reset values
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 16'd16000;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 16'd100;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST   = 16'd20000;
  localparam logic [GAIN_W-1:0]  INTEG_WINDOW_RST = 16'd250;
  localparam logic [DIV_W-1:0]   OUT_DIVISOR_RST  = 16'd20000;
  localparam logic [DRIVE_W-1:0] OUT_MIN_RST      = 8'd0;
  localparam logic [DRIVE_W-1:0] OUT_MAX_RST      = 8'd100;

endpackage

`default_nettype wire

FILE: src/incremental_pid_drive.sv
// ----------------------------------------------------------------------------
// incremental_pid_drive: velocity-form PID controller with clamped drive
// Per sample forms the error, updates a saturating control sum by the
// proportional, windowed integral and derivative increments, scales the
// sum by a divisor and clamps the result to the drive limits.
// ----------------------------------------------------------------------------
// Each sample goes from acceptance to its drive beat in these steps: the
// error differences are formed, the three gain products are taken on a
// shared multiplier (multiply, then accumulate), the sum is saturated, and
// the bit-serial divider, which takes most of the time, feeds the final
// clamp. s_tready is high only while the block is idle, so no new sample
// is taken before the last is done; a finished drive value sits in an
// output register, so the next sample can be accepted while that beat
// waits for m_tready. Configuration registers are written through cfg_we,
// cfg_index and cfg_data by the user only while the block is idle; the block does not enforce it.
`default_nettype none

module incremental_pid_drive #(
  parameter int SAMPLE_BITS = ipd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input samples
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [31:0]                   s_tdata,   // [15:0] set_point, [31:16] process_value
  // drive output
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [7:0]                         m_tdata,   // [7:0] drive
  // configuration writes
  input  wire logic                          cfg_we,
  input  wire logic [ipd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ipd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int EW  = SAMPLE_BITS + 1;          // error
  localparam int D1W = SAMPLE_BITS + 2;          // e - e1
  localparam int D2W = SAMPLE_BITS + 3;          // e - 2e1 + e2
  localparam int PW  = ipd_pkg::GAIN_W + 1 + D2W; // gain product
  localparam int AW  = ipd_pkg::ACC_W;
  localparam int SW  = ipd_pkg::SUM_W;
  localparam int QW  = SW + 2;                   // signed quotient for clamp

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ERR  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_SAT  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // product terms
  localparam logic [1:0] T_PROP  = 2'd0;
  localparam logic [1:0] T_INTEG = 2'd1;
  localparam logic [1:0] T_DERIV = 2'd2;

  // configuration registers
  logic [ipd_pkg::GAIN_W-1:0]  prop_gain;
  logic [ipd_pkg::GAIN_W-1:0]  integ_gain;
  logic [ipd_pkg::GAIN_W-1:0]  deriv_gain;
  logic [ipd_pkg::GAIN_W-1:0]  integ_window;
  logic [ipd_pkg::DIV_W-1:0]   out_divisor;
  logic [ipd_pkg::DRIVE_W-1:0] out_min;
  logic [ipd_pkg::DRIVE_W-1:0] out_max;

  // loop state and working registers
  logic [2:0]             state;
  logic [1:0]             term;
  logic signed [SW-1:0]   control_sum;
  logic signed [EW-1:0]   last_error;
  logic signed [EW-1:0]   older_error;
  logic signed [EW-1:0]   err;
  logic signed [D1W-1:0]  diff1;
  logic signed [D2W-1:0]  diff2;
  logic                   in_window;
  logic signed [PW-1:0]   prod;
  logic signed [AW-1:0]   acc;
  logic                   negative;

  // combinational helpers
  logic [SAMPLE_BITS-1:0]      sp;
  logic [SAMPLE_BITS-1:0]      pv;
  logic signed [EW-1:0]        err_new;
  logic [EW-1:0]               err_mag;
  logic [ipd_pkg::GAIN_W-1:0]  mul_gain;
  logic signed [D2W-1:0]       mul_opnd;
  logic signed [SW-1:0]        sat_sum;
  logic [SW-1:0]               sat_mag;
  logic [ipd_pkg::DIV_W-1:0]   divisor_eff;
  logic                        div_start;
  logic                        div_done;
  logic [SW-1:0]               div_quo;
  logic signed [QW-1:0]        q_signed;
  logic [ipd_pkg::DRIVE_W-1:0] drive;
  logic                        out_free;

  // configuration writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= ipd_pkg::PROP_GAIN_RST;
      integ_gain   <= ipd_pkg::INTEG_GAIN_RST;
      deriv_gain   <= ipd_pkg::DERIV_GAIN_RST;
      integ_window <= ipd_pkg::INTEG_WINDOW_RST;
      out_divisor  <= ipd_pkg::OUT_DIVISOR_RST;
      out_min      <= ipd_pkg::OUT_MIN_RST;
      out_max      <= ipd_pkg::OUT_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipd_pkg::REG_PROP_GAIN:    prop_gain    <= cfg_data;
        ipd_pkg::REG_INTEG_GAIN:   integ_gain   <= cfg_data;
        ipd_pkg::REG_DERIV_GAIN:   deriv_gain   <= cfg_data;
        ipd_pkg::REG_INTEG_WINDOW: integ_window <= cfg_data;
        ipd_pkg::REG_OUT_DIVISOR:  out_divisor  <= cfg_data;
        ipd_pkg::REG_OUT_MIN:      out_min      <= cfg_data[ipd_pkg::DRIVE_W-1:0];
        ipd_pkg::REG_OUT_MAX:      out_max      <= cfg_data[ipd_pkg::DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // error and its magnitude from the current beat
  always_comb begin
    sp      = s_tdata[SAMPLE_BITS-1:0];
    pv      = s_tdata[16 +: SAMPLE_BITS];
    err_new = EW'(sp) - EW'(pv);
    err_mag = err_new[EW-1] ? EW'(-err_new) : EW'(err_new);
  end

  // shared multiplier operand select
  always_comb begin
    case (term)
      T_PROP: begin
        mul_gain = prop_gain;
        mul_opnd = D2W'(diff1);
      end
      T_INTEG: begin
        mul_gain = in_window ? integ_gain : '0;
        mul_opnd = D2W'(err);
      end
      default: begin
        mul_gain = deriv_gain;
        mul_opnd = diff2;
      end
    endcase
  end

  // saturation to 32 bits and magnitude for the divider
  always_comb begin
    if (acc > AW'(signed'({1'b0, {(SW-1){1'b1}}}))) begin
      sat_sum = {1'b0, {(SW-1){1'b1}}};
    end else if (acc < AW'(signed'({1'b1, {(SW-1){1'b0}}}))) begin
      sat_sum = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sat_sum = acc[SW-1:0];
    end
    sat_mag     = sat_sum[SW-1] ? SW'(-sat_sum) : SW'(sat_sum);
    divisor_eff = (out_divisor == '0) ? ipd_pkg::DIV_W'(1) : out_divisor;
    div_start   = (state == S_SAT);
  end

  // clamp of the signed quotient
  always_comb begin
    q_signed = negative ? -QW'(div_quo) : QW'(div_quo);
    if (q_signed < signed'(QW'(out_min))) begin
      drive = out_min;
    end else if (q_signed > signed'(QW'(out_max))) begin
      drive = out_max;
    end else begin
      drive = q_signed[ipd_pkg::DRIVE_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      term        <= T_PROP;
      control_sum <= '0;
      last_error  <= '0;
      older_error <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_ERR;
          end
        end
        S_ERR: begin
          older_error <= last_error;
          last_error  <= err;
          term        <= T_PROP;
          state       <= S_MUL;
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          if (term == T_DERIV) begin
            state <= S_SAT;
          end else begin
            term  <= term + 1'b1;
            state <= S_MUL;
          end
        end
        S_SAT: begin
          control_sum <= sat_sum;
          state       <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // drive beat valid: set on a finished sample, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      err       <= err_new;
      in_window <= 17'(err_mag) < {1'b0, integ_window};
    end
    if (state == S_ERR) begin
      diff1 <= D1W'(err) - D1W'(last_error);
      diff2 <= D2W'(err) - (D2W'(last_error) <<< 1) + D2W'(older_error);
      acc   <= AW'(control_sum);
    end
    if (state == S_MUL) begin
      prod <= signed'({1'b0, mul_gain}) * mul_opnd;
    end
    if (state == S_ADD) begin
      acc <= acc + AW'(prod);
    end
    if (state == S_SAT) begin
      negative <= sat_sum[SW-1];
    end
    if (state == S_DONE && out_free) begin
      m_tdata <= drive;
    end
  end

  ipd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sat_mag),
    .divisor  (divisor_eff),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

`default_nettype wire

FILE: src/ipd_div.sv
// ----------------------------------------------------------------------------
// ipd_div: iterative unsigned divider
// Restoring division of a 32-bit magnitude by a 16-bit divisor, one
// quotient bit per cycle. done pulses once the quotient is complete.
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [ipd_pkg::SUM_W-1:0] dividend,
  input  wire logic [ipd_pkg::DIV_W-1:0] divisor,
  output logic                          done,
  output logic [ipd_pkg::SUM_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(ipd_pkg::SUM_W);

  logic                        busy;
  logic [CNT_W-1:0]            count;
  logic [ipd_pkg::DIV_W-1:0]   rem;
  logic [ipd_pkg::DIV_W-1:0]   dvsr;
  logic [ipd_pkg::DIV_W:0]     shifted;
  logic [ipd_pkg::DIV_W+1:0]   trial;

  // one restoring step: shift in the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem, quotient[ipd_pkg::SUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvsr};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(ipd_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (trial[ipd_pkg::DIV_W+1]) begin
        rem <= shifted[ipd_pkg::DIV_W-1:0];
      end else begin
        rem <= trial[ipd_pkg::DIV_W-1:0];
      end
      quotient <= {quotient[ipd_pkg::SUM_W-2:0], ~trial[ipd_pkg::DIV_W+1]};
    end
  end

endmodule

`default_nettype wire
